[sv/stc_pkg.sv]
package stc_pkg;

    // fixed widths of the output word fields
    localparam int OFS_W      = 24;
    localparam int LINE_OUT_W = 16;
    localparam int LEN_W      = 16;
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    // keyword prefix store: first six bytes, byte i in bits 8i+7..8i
    localparam int PFX_BYTES = 6;
    localparam int PFX_W     = 8 * PFX_BYTES;
    localparam logic [PFX_W-1:0] PFX_INT    = 48'h0000_0074_6E69;
    localparam logic [PFX_W-1:0] PFX_RETURN = 48'h6E72_7574_6572;
    localparam logic [LEN_W-1:0] LEN_KW_INT    = 16'd3;
    localparam logic [LEN_W-1:0] LEN_KW_RETURN = 16'd6;

    localparam logic [7:0] CH_LF = 8'h0A;

    // defaults for top-level parameters
    localparam int DEF_POSITION_WIDTH = 24;
    localparam int DEF_LINE_WIDTH     = 16;

    // queue depths (token queue depth must be a power of two)
    localparam int BQ_DEPTH = 2;
    localparam int TQ_DEPTH = 4;

    // config port
    localparam int APB_ADDR_W = 1;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] REG_START_LINE = 1'b0;
    localparam logic [15:0] START_LINE_RESET = 16'd1;

    typedef enum logic [2:0] {
        CLS_SPACE,
        CLS_ALPHA,
        CLS_DIGIT,
        CLS_PUNCT,
        CLS_EOF,
        CLS_UNKNOWN
    } cls_t;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_INT
    } mode_t;

    typedef enum logic [2:0] {
        KIND_IDENT     = 3'd0,
        KIND_INTEGER   = 3'd1,
        KIND_KW_INT    = 3'd2,
        KIND_KW_RETURN = 3'd3,
        KIND_PUNCT     = 3'd4,
        KIND_UNKNOWN   = 3'd5,
        KIND_EOF       = 3'd6
    } kind_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       final_byte;
    } in_word_t;

    typedef struct packed {
        kind_t                 kind;
        logic [LINE_OUT_W-1:0] line;
        logic [OFS_W-1:0]      start_offset;
        logic [LEN_W-1:0]      length;
        logic                  last_of_run;
    } tok_t;

    // classified byte handed from front to back
    typedef struct packed {
        cls_t                  cls;
        logic [7:0]            ch;
        logic                  final_byte;
        logic [OFS_W-1:0]      pos;
        logic [LINE_OUT_W-1:0] line;
    } byte_item_t;

    // up to two tokens written per cycle into the token queue
    typedef struct packed {
        logic [1:0] cnt;
        tok_t       t0;
        tok_t       t1;
    } tok_push_t;

    function automatic cls_t classify(input logic [7:0] c);
        cls_t r;
        case (c) inside
            8'h20, [8'h09:8'h0D]:                 r = CLS_SPACE;
            [8'h61:8'h7A], [8'h41:8'h5A]:         r = CLS_ALPHA;
            [8'h30:8'h39]:                        r = CLS_DIGIT;
            8'h28, 8'h29, 8'h7B, 8'h7D, 8'h3B:    r = CLS_PUNCT;
            8'h00:                                r = CLS_EOF;
            default:                              r = CLS_UNKNOWN;
        endcase
        return r;
    endfunction

    function automatic kind_t open_kind(input mode_t m, input logic [LEN_W-1:0] len,
                                        input logic [PFX_W-1:0] pfx);
        kind_t r;
        r = KIND_INTEGER;
        if (m == MODE_IDENT) begin
            if (len == LEN_KW_INT && pfx == PFX_INT)
                r = KIND_KW_INT;
            else if (len == LEN_KW_RETURN && pfx == PFX_RETURN)
                r = KIND_KW_RETURN;
            else
                r = KIND_IDENT;
        end
        return r;
    endfunction

endpackage

[sv/source_char_tokenizer.sv]
// Bytes pass through the byte queue to the scanner, whose tokens go to the token queue (head on tok).
// Throughput: one byte per cycle while the token queue has room for two tokens; each byte may queue
// up to two tokens, and one token leaves per pop, so the single result port sets the rate when
// tokens outnumber bytes. Reset (rst_n low, async): queues empty, scanner idle, byte position 0,
// start_line and line counter 1. No clearing pass; the block takes words once reset is released.
module source_char_tokenizer #(
    parameter int POSITION_WIDTH = stc_pkg::DEF_POSITION_WIDTH,
    parameter int LINE_WIDTH     = stc_pkg::DEF_LINE_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // byte input queue side
    input  logic                            push,
    output logic                            full,
    input  stc_pkg::in_word_t               src,
    // token output queue side
    output logic                            empty,
    input  logic                            pop,
    output stc_pkg::tok_t                   tok,
    // config port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [stc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [stc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [stc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    logic                accept;
    stc_pkg::byte_item_t front_item;
    stc_pkg::byte_item_t back_item;
    logic                bq_empty;
    logic                bq_pop;
    logic                tq_room2;
    logic                tq_empty;
    stc_pkg::tok_push_t  tpush;

    // a word is taken whenever the byte queue has a free slot
    assign accept = push && !full;

    // Front: position/line tracking, char classification, config register.
    // Position and line ride with each byte so the back end never sees config.
    stc_front #(
        .POSITION_WIDTH (POSITION_WIDTH),
        .LINE_WIDTH     (LINE_WIDTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .src     (src),
        .item    (front_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // short queue of classified bytes between front and back
    stc_byteq u_byteq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (front_item),
        .rd_en   (bq_pop),
        .rd_data (back_item),
        .full    (full),
        .empty   (bq_empty)
    );

    // Back: token scanner. Takes one byte when the token queue has room for two tokens
    // (close of the open token plus a one-byte token or the final flush).
    stc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (back_item),
        .item_valid (!bq_empty),
        .item_pop   (bq_pop),
        .room2      (tq_room2),
        .tpush      (tpush)
    );

    // token queue; head entry drives the result ports
    stc_tokq u_tokq (
        .clk     (clk),
        .rst_n   (rst_n),
        .tpush   (tpush),
        .rd_en   (pop && !tq_empty),
        .rd_data (tok),
        .room2   (tq_room2),
        .empty   (tq_empty)
    );

    assign empty = tq_empty;

endmodule

[sv/stc_front.sv]
module stc_front #(
    parameter int POSITION_WIDTH = stc_pkg::DEF_POSITION_WIDTH,
    parameter int LINE_WIDTH     = stc_pkg::DEF_LINE_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  stc_pkg::in_word_t               src,
    output stc_pkg::byte_item_t             item,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [stc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [stc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [stc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam logic [POSITION_WIDTH-1:0] POS_MAX  = {POSITION_WIDTH{1'b1}};
    localparam logic [LINE_WIDTH-1:0]     LINE_MAX = {LINE_WIDTH{1'b1}};
    localparam logic [31:0] LINE_MAX32 = 32'((64'd1 << LINE_WIDTH) - 64'd1);

    logic [POSITION_WIDTH-1:0] pos_reg, pos_next;
    logic [LINE_WIDTH-1:0]     line_reg, line_next;
    logic [15:0]               start_line_reg, start_line_next;
    logic                      cfg_wr;
    logic [31:0]               wr_val;
    logic [31:0]               wr_clamped;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == stc_pkg::REG_START_LINE);

    // start_line is clamped to the line counter range
    assign wr_val     = 32'(pwdata[15:0]);
    assign wr_clamped = (wr_val > LINE_MAX32) ? LINE_MAX32 : wr_val;

    always_comb
    begin
        prdata = '0;
        if (paddr == stc_pkg::REG_START_LINE)
            prdata = 32'(start_line_reg);
    end

    always_comb
    begin
        pos_next        = pos_reg;
        line_next       = line_reg;
        start_line_next = start_line_reg;
        if (cfg_wr)
        begin
            start_line_next = 16'(wr_clamped);
            line_next       = LINE_WIDTH'(wr_clamped);
        end
        else if (accept)
        begin
            if (pos_reg != POS_MAX)
                pos_next = pos_reg + 1'b1;
            if (src.ch == stc_pkg::CH_LF && line_reg != LINE_MAX)
                line_next = line_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            line_reg       <= LINE_WIDTH'(stc_pkg::START_LINE_RESET);
            start_line_reg <= stc_pkg::START_LINE_RESET;
        end
        else
        begin
            pos_reg        <= pos_next;
            line_reg       <= line_next;
            start_line_reg <= start_line_next;
        end
    end

    // position and line as seen before this byte, masked to output widths
    always_comb
    begin
        item.cls        = stc_pkg::classify(src.ch);
        item.ch         = src.ch;
        item.final_byte = src.final_byte;
        item.pos        = stc_pkg::OFS_W'(pos_reg);
        item.line       = stc_pkg::LINE_OUT_W'(line_reg);
    end

endmodule

[sv/stc_byteq.sv]
module stc_byteq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  stc_pkg::byte_item_t wr_data,
    input  logic                rd_en,
    output stc_pkg::byte_item_t rd_data,
    output logic                full,
    output logic                empty
);

    localparam int DEPTH = stc_pkg::BQ_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    stc_pkg::byte_item_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            cnt_next = cnt_reg + 1'b1;
        else if (!wr_en && rd_en)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

[sv/stc_back.sv]
module stc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  stc_pkg::byte_item_t item,
    input  logic                item_valid,
    output logic                item_pop,
    input  logic                room2,
    output stc_pkg::tok_push_t  tpush
);

    localparam int LEN_W = stc_pkg::LEN_W;

    stc_pkg::mode_t            mode_reg, mode_next;
    logic [stc_pkg::OFS_W-1:0]      open_start_reg, open_start_next;
    logic [stc_pkg::LINE_OUT_W-1:0] open_line_reg, open_line_next;
    logic [LEN_W-1:0]               open_len_reg, open_len_next;
    logic [stc_pkg::PFX_W-1:0]      pfx_reg, pfx_next;

    logic          extended;
    logic          have_close;
    logic          have_second;
    stc_pkg::tok_t close_tok;
    stc_pkg::tok_t second_tok;

    assign item_pop = item_valid && room2;

    always_comb
    begin
        mode_next       = mode_reg;
        open_start_next = open_start_reg;
        open_line_next  = open_line_reg;
        open_len_next   = open_len_reg;
        pfx_next        = pfx_reg;
        have_close      = 1'b0;
        have_second     = 1'b0;

        close_tok.kind         = stc_pkg::open_kind(mode_reg, open_len_reg, pfx_reg);
        close_tok.line         = open_line_reg;
        close_tok.start_offset = open_start_reg;
        close_tok.length       = open_len_reg;
        close_tok.last_of_run  = 1'b0;

        second_tok.kind         = stc_pkg::KIND_UNKNOWN;
        second_tok.line         = item.line;
        second_tok.start_offset = item.pos;
        second_tok.length       = LEN_W'(1);
        second_tok.last_of_run  = 1'b1;

        extended = ((mode_reg == stc_pkg::MODE_IDENT) &&
                    (item.cls == stc_pkg::CLS_ALPHA || item.cls == stc_pkg::CLS_DIGIT)) ||
                   ((mode_reg == stc_pkg::MODE_INT) && (item.cls == stc_pkg::CLS_DIGIT));

        if (extended)
        begin
            for (int i = 0; i < stc_pkg::PFX_BYTES; i++)
            begin
                if (open_len_reg == LEN_W'(i))
                    pfx_next[8*i +: 8] = pfx_reg[8*i +: 8] | item.ch;
            end
            if (open_len_reg != stc_pkg::LEN_MAX)
                open_len_next = open_len_reg + 1'b1;
        end
        else
        begin
            have_close = (mode_reg == stc_pkg::MODE_IDENT) || (mode_reg == stc_pkg::MODE_INT);
            mode_next  = stc_pkg::MODE_IDLE;
            case (item.cls)
                stc_pkg::CLS_SPACE:
                begin
                end
                stc_pkg::CLS_ALPHA, stc_pkg::CLS_DIGIT:
                begin
                    mode_next       = (item.cls == stc_pkg::CLS_ALPHA) ?
                                      stc_pkg::MODE_IDENT : stc_pkg::MODE_INT;
                    open_start_next = item.pos;
                    open_line_next  = item.line;
                    open_len_next   = LEN_W'(1);
                    pfx_next        = stc_pkg::PFX_W'(item.ch);
                end
                stc_pkg::CLS_PUNCT:
                begin
                    have_second     = 1'b1;
                    second_tok.kind = stc_pkg::KIND_PUNCT;
                end
                stc_pkg::CLS_EOF:
                begin
                    have_second     = 1'b1;
                    second_tok.kind = stc_pkg::KIND_EOF;
                end
                default:
                begin
                    have_second     = 1'b1;
                    second_tok.kind = stc_pkg::KIND_UNKNOWN;
                end
            endcase
        end

        // last byte flushes whatever token is open after this byte
        if (item.final_byte &&
            (mode_next == stc_pkg::MODE_IDENT || mode_next == stc_pkg::MODE_INT))
        begin
            have_second             = 1'b1;
            second_tok.kind         = stc_pkg::open_kind(mode_next, open_len_next, pfx_next);
            second_tok.line         = open_line_next;
            second_tok.start_offset = open_start_next;
            second_tok.length       = open_len_next;
            mode_next               = stc_pkg::MODE_IDLE;
        end

        close_tok.last_of_run = !have_second;

        tpush.cnt = '0;
        if (item_pop)
            tpush.cnt = 2'(have_close) + 2'(have_second);
        tpush.t0 = have_close ? close_tok : second_tok;
        tpush.t1 = second_tok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= stc_pkg::MODE_IDLE;
            open_start_reg <= '0;
            open_line_reg  <= '0;
            open_len_reg   <= '0;
            pfx_reg        <= '0;
        end
        else if (item_pop)
        begin
            mode_reg       <= mode_next;
            open_start_reg <= open_start_next;
            open_line_reg  <= open_line_next;
            open_len_reg   <= open_len_next;
            pfx_reg        <= pfx_next;
        end
    end

endmodule

[sv/stc_tokq.sv]
module stc_tokq (
    input  logic               clk,
    input  logic               rst_n,
    input  stc_pkg::tok_push_t tpush,
    input  logic               rd_en,
    output stc_pkg::tok_t      rd_data,
    output logic               room2,
    output logic               empty
);

    localparam int DEPTH = stc_pkg::TQ_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    stc_pkg::tok_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [PTR_W-1:0] wr_ptr_p1;

    assign empty     = (cnt_reg == '0);
    assign room2     = (cnt_reg <= CNT_W'(DEPTH - 2));
    assign rd_data   = slot_reg[rd_ptr_reg];
    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;
    assign cnt_next  = cnt_reg + CNT_W'(tpush.cnt) - CNT_W'(rd_en);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(tpush.cnt);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(rd_en);
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tpush.cnt != 2'd0)
            slot_reg[wr_ptr_reg] <= tpush.t0;
        if (tpush.cnt == 2'd2)
            slot_reg[wr_ptr_p1] <= tpush.t1;
    end

endmodule

[tb/sv/tb_top.sv]
module tb_top;
    import stc_pkg::*;

    localparam int CLK_PERIOD       = 20;
    localparam int RESET_CYCLES     = 9;
    // hard stop
    localparam int RUN_LIMIT_CYCLES = 400_000;
    // scan stage plus token queue, with margin, for words that leave no token
    localparam int DRAIN_CYCLES     = 8;
    localparam int IDLE_PCT         = 30;
    localparam int RANDOM_WORDS     = 1800;
    localparam int PHASES           = 4;
    localparam int NEAR_WORDS       = 10;
    // "return" plus this many more bytes runs well past the keyword prefix
    localparam int LONG_EXTRA       = 64;

    localparam logic [OFS_W-1:0]      POS_MAX  = {OFS_W{1'b1}};
    localparam logic [LINE_OUT_W-1:0] LINE_MAX = {LINE_OUT_W{1'b1}};

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = "(";
    localparam logic [7:0] CH_RPAREN = ")";
    localparam logic [7:0] CH_LBRACE = "{";
    localparam logic [7:0] CH_RBRACE = "}";
    localparam logic [7:0] CH_SEMI   = ";";

    // ------------------------------------------------------------------
    // DUT hookup; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic                  clk     = 1'b0;
    logic                  rst_n   = 1'b0;
    logic                  push    = 1'b0;
    logic                  full;
    in_word_t              src     = '0;
    logic                  empty;
    logic                  pop     = 1'b0;
    tok_t                  tok;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    source_char_tokenizer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .src     (src),
        .empty   (empty),
        .pop     (pop),
        .tok     (tok),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Lexer state as the scanner should hold it
    // ------------------------------------------------------------------
    mode_t                 lex_mode       = MODE_IDLE;
    logic [OFS_W-1:0]      cur_pos        = '0;
    logic [LINE_OUT_W-1:0] cur_line       = START_LINE_RESET;
    logic [LINE_OUT_W-1:0] start_line_reg = START_LINE_RESET;
    logic [OFS_W-1:0]      tok_start      = '0;
    logic [LINE_OUT_W-1:0] tok_line       = '0;
    logic [LEN_W-1:0]      tok_len        = '0;
    logic [PFX_W-1:0]      tok_prefix     = '0;

    tok_t step_toks[$];     // tokens raised by the word being scanned
    tok_t pending_toks[$];  // tokens owed by the DUT, oldest first

    int errors     = 0;
    int words_sent = 0;
    bit calm       = 1'b0;  // set: neither side idles

    logic [7:0] punct_chars [5] = '{CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_SEMI};
    // newline weighted double so line numbers move along
    logic [7:0] space_chars [8] = '{CH_SPACE, CH_TAB, CH_LF, CH_LF, CH_VT, CH_FF, CH_CR,
                                    CH_SPACE};
    // keywords and the identifiers that nearly match them
    string near_words [NEAR_WORDS] = '{"int", "return", "in", "inta", "Int", "retur",
                                       "returnx", "return9", "rEturn", "int0"};

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void emit_token(kind_t k, logic [LINE_OUT_W-1:0] ln,
                                       logic [OFS_W-1:0] start, logic [LEN_W-1:0] len);
        tok_t t;
        t.kind         = k;
        t.line         = ln;
        t.start_offset = start;
        t.length       = len;
        t.last_of_run  = 1'b0;
        step_toks.push_back(t);
    endfunction

    // Close the open identifier or integer. Keywords need both the exact
    // length and the stored prefix, so "returnx" stays an identifier.
    function automatic void close_open();
        kind_t k;
        k = KIND_INTEGER;
        if (lex_mode == MODE_IDENT)
        begin
            k = KIND_IDENT;
            if (tok_len == LEN_KW_INT && tok_prefix == PFX_INT)
                k = KIND_KW_INT;
            else if (tok_len == LEN_KW_RETURN && tok_prefix == PFX_RETURN)
                k = KIND_KW_RETURN;
        end
        emit_token(k, tok_line, tok_start, tok_len);
        lex_mode = MODE_IDLE;
    endfunction

    function automatic void open_token(mode_t m, logic [7:0] c);
        lex_mode   = m;
        tok_start  = cur_pos;
        tok_line   = cur_line;
        tok_len    = LEN_W'(1);
        tok_prefix = {{(PFX_W-8){1'b0}}, c};
    endfunction

    // Advance the lexer by one accepted word and queue what it owes.
    function automatic void predict_tokens(in_word_t w);
        logic [7:0] c;
        bit         grows;
        kind_t      k;
        c = w.ch;
        step_toks.delete();
        grows = (lex_mode == MODE_IDENT && (is_letter(c) || is_digit(c))) ||
                (lex_mode == MODE_INT && is_digit(c));
        if (grows)
        begin
            // only the first six bytes are kept for keyword matching
            if (tok_len < PFX_BYTES)
                tok_prefix[8*int'(tok_len) +: 8] = c;
            if (tok_len != LEN_MAX)
                tok_len++;
        end
        else
        begin
            // a byte that cannot extend closes the token, then is scanned itself
            if (lex_mode == MODE_IDENT || lex_mode == MODE_INT)
                close_open();
            lex_mode = MODE_IDLE;
            if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
                c == CH_FF || c == CH_CR)
            begin
                if (c == CH_LF && cur_line != LINE_MAX)
                    cur_line++;
            end
            else if (is_letter(c))
            begin
                open_token(MODE_IDENT, c);
            end
            else if (is_digit(c))
            begin
                open_token(MODE_INT, c);
            end
            else
            begin
                // NUL is end of file but scanning carries on; bytes >= 128 are unknown
                k = KIND_UNKNOWN;
                if (c == CH_NUL)
                    k = KIND_EOF;
                else if (c == CH_LPAREN || c == CH_RPAREN || c == CH_LBRACE ||
                         c == CH_RBRACE || c == CH_SEMI)
                    k = KIND_PUNCT;
                emit_token(k, cur_line, cur_pos, LEN_W'(1));
            end
        end
        // last byte of the source flushes whatever is still open
        if (w.final_byte && (lex_mode == MODE_IDENT || lex_mode == MODE_INT))
            close_open();
        // position and line keep counting across sources
        if (cur_pos != POS_MAX)
            cur_pos++;
        if (step_toks.size() > 0)
            step_toks[step_toks.size()-1].last_of_run = 1'b1;
        foreach (step_toks[i])
            pending_toks.push_back(step_toks[i]);
    endfunction

    task automatic report_mismatch(string field, int unsigned want, int unsigned got);
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Token side: random pop, compare each popped token with the oldest
    // prediction. pop and empty read here are the values at this edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        tok_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_toks.size() == 0)
            begin
                $error("token kind %0d at offset %0d with none expected",
                       tok.kind, tok.start_offset);
                errors++;
            end
            else
            begin
                want = pending_toks.pop_front();
                if (tok.kind !== want.kind)
                    report_mismatch("kind", 32'(want.kind), 32'(tok.kind));
                if (tok.line !== want.line)
                    report_mismatch("line", 32'(want.line), 32'(tok.line));
                if (tok.start_offset !== want.start_offset)
                    report_mismatch("start_offset", 32'(want.start_offset),
                                    32'(tok.start_offset));
                if (tok.length !== want.length)
                    report_mismatch("length", 32'(want.length), 32'(tok.length));
                if (tok.last_of_run !== want.last_of_run)
                    report_mismatch("last_of_run", 32'(want.last_of_run),
                                    32'(tok.last_of_run));
            end
        end
        pop <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // Byte side
    // ------------------------------------------------------------------
    // push stays high between back-to-back words; it only drops for a gap
    task automatic feed_byte(input logic [7:0] c, input bit fin);
        in_word_t w;
        w.ch         = c;
        w.final_byte = fin;
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        src  <= w;
        do @(posedge clk); while (full);
        predict_tokens(w);
        words_sent++;
    endtask

    task automatic feed_text(input string s, input bit fin_last);
        for (int i = 0; i < s.len(); i++)
            feed_byte(s[i], fin_last && (i == s.len() - 1));
    endtask

    // stop feeding and wait out every owed token, then the scan pipe
    task automatic settle();
        push <= 1'b0;
        while (pending_toks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Config port; after the access psel drops and the task waits on the clock again, so calls never overlap
    // ------------------------------------------------------------------
    task automatic apb_access(input bit wr, input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= REG_START_LINE;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_start_line();
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b0, '0, rd);
        if (rd !== {{(APB_DATA_W-LINE_OUT_W){1'b0}}, start_line_reg})
            report_mismatch("start_line", 32'(start_line_reg), rd);
    endtask

    // upper data bits are junk; only the low 16 belong to the register
    task automatic set_start_line(input logic [LINE_OUT_W-1:0] v);
        logic [APB_DATA_W-1:0] junk;
        logic [APB_DATA_W-1:0] rd;
        junk = $urandom;
        apb_access(1'b1, {junk[APB_DATA_W-1:LINE_OUT_W], v}, rd);
        // the write reloads the running line counter too
        start_line_reg = v;
        cur_line       = v;
        check_start_line();
    endtask

    // ------------------------------------------------------------------
    // Random source text helpers
    // ------------------------------------------------------------------
    function automatic bit rare_final();
        return $urandom_range(39) == 0;
    endfunction

    function automatic logic [7:0] random_letter();
        if ($urandom_range(1))
            return 8'("a" + $urandom_range(25));
        return 8'("A" + $urandom_range(25));
    endfunction

    function automatic logic [7:0] random_alnum();
        if ($urandom_range(2) == 0)
            return 8'("0" + $urandom_range(9));
        return random_letter();
    endfunction

    // one lexical piece; pieces butt together, so a piece often closes the last one
    task automatic random_piece();
        int sel;
        int n;
        sel = $urandom_range(99);
        if (sel < 20)
        begin
            feed_text(near_words[$urandom_range(NEAR_WORDS - 1)], rare_final());
        end
        else if (sel < 40)
        begin
            n = $urandom_range(1, 8);
            feed_byte(random_letter(), rare_final());
            repeat (n - 1) feed_byte(random_alnum(), rare_final());
        end
        else if (sel < 55)
        begin
            n = $urandom_range(1, 6);
            repeat (n) feed_byte(8'("0" + $urandom_range(9)), rare_final());
        end
        else if (sel < 67)
        begin
            feed_byte(punct_chars[$urandom_range(4)], rare_final());
        end
        else if (sel < 90)
        begin
            feed_byte(space_chars[$urandom_range(7)], rare_final());
        end
        else if (sel < 93)
        begin
            feed_byte(CH_NUL, rare_final());
        end
        else
        begin
            // noise: any byte at all
            feed_byte(8'($urandom_range(255)), rare_final());
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_value();
        check_start_line();
    endtask

    // Every kind, every blank but space, bytes 0x80/0xFF/NUL, a byte that closes an
    // identifier and emits punctuation, and a final byte that closes an integer,
    // opens an identifier and flushes it in one go.
    task automatic test_token_kinds();
        feed_text("int(return)9a;\t{", 1'b0);
        feed_byte(CH_VT, 1'b0);
        feed_byte(CH_FF, 1'b0);
        feed_byte(CH_CR, 1'b0);
        feed_byte(CH_LF, 1'b0);
        feed_byte(8'h80, 1'b0);
        feed_byte(8'hFF, 1'b0);
        feed_byte(CH_NUL, 1'b0);
        feed_text("}12x", 1'b1);
    endtask

    // line counter pinned at its ceiling, then counting from zero
    task automatic test_line_numbers();
        settle();
        set_start_line(LINE_MAX - 1'b1);
        feed_text("a\n;\n\nb", 1'b1);
        settle();
        set_start_line('0);
        feed_byte(CH_LF, 1'b0);
        feed_text("7 ", 1'b1);
    endtask

    // a long identifier that starts like a keyword, fed back to back
    task automatic test_long_identifier();
        settle();
        calm = 1'b1;
        feed_text("return", 1'b0);
        for (int i = 0; i < LONG_EXTRA; i++)
            feed_byte(random_alnum(), i == LONG_EXTRA - 1);
        calm = 1'b0;
    endtask

    // random source in phases, each under its own start line;
    // the last phase runs with no idling on either side
    task automatic test_random_source();
        int target;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            if (ph == 0)
                set_start_line(LINE_OUT_W'($urandom));
            else if (ph == 1)
                set_start_line('0);
            else if (ph == 2)
                set_start_line(LINE_MAX);
            else
                set_start_line(LINE_OUT_W'($urandom_range(1, 200)));
            calm   = (ph == PHASES - 1);
            target = words_sent + RANDOM_WORDS / PHASES;
            while (words_sent < target)
                random_piece();
        end
        calm = 1'b0;
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_value();
        test_token_kinds();
        test_line_numbers();
        test_long_identifier();
        test_random_source();
        settle();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog
    initial
    begin
        #(CLK_PERIOD * RUN_LIMIT_CYCLES);
        $display("FAILURE");
        $finish;
    end

endmodule
